@@ rtl/sstbl_pkg.sv @@
// Shared types and constants for the sorted set table.
// Used by the controller, the datapath and the top level.
package sstbl_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_TEST   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture compare results for the incoming key
      logic shift_up;    // open a slot and write the key
      logic shift_down;  // close the slot holding the key
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit;
      logic full;
   } dp_stat_type;

endpackage

@@ rtl/sstbl_ctrl.sv @@
// Controller for the sorted set table: two-state sequencer, decides the
// update and registers the response. Depends on sstbl_pkg.
module sstbl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   output sstbl_pkg::dp_cmd_type cmd,
   input  sstbl_pkg::dp_stat_type stat,
   output logic                  rsp_valid,
   output logic                  rsp_success,
   output logic                  rsp_full_error
);
   import sstbl_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type  state_ff;
   logic [1:0] op_ff;
   logic       rsp_valid_ff;
   logic       rsp_success_ff;
   logic       rsp_full_error_ff;

   logic do_ins;
   logic do_del;
   logic is_test;

   assign is_test = (op_ff == OP_TEST);
   assign do_ins  = (op_ff == OP_INSERT) && !stat.hit && !stat.full;
   assign do_del  = (op_ff == OP_DELETE) && stat.hit;

   assign busy           = (state_ff == ST_EXEC);
   assign cmd.load       = (state_ff == ST_IDLE) && start;
   assign cmd.shift_up   = (state_ff == ST_EXEC) && do_ins;
   assign cmd.shift_down = (state_ff == ST_EXEC) && do_del;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         op_ff             <= OP_TEST;
         rsp_valid_ff      <= 1'b0;
         rsp_success_ff    <= 1'b0;
         rsp_full_error_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  op_ff    <= req_op;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_valid_ff      <= 1'b1;
               rsp_success_ff    <= (is_test && stat.hit) || do_ins || do_del;
               rsp_full_error_ff <= (op_ff == OP_INSERT) && !stat.hit && stat.full;
               state_ff          <= ST_IDLE;
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = rsp_success_ff;
   assign rsp_full_error = rsp_full_error_ff;

endmodule

@@ rtl/sstbl_dp.sv @@
// Datapath for the sorted set table: a row of key cells, each with its own
// comparator and a shift path to both neighbors, plus the fill count.
// Depends on sstbl_pkg.
module sstbl_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic signed [31:0]      req_key,
   input  sstbl_pkg::dp_cmd_type   cmd,
   output sstbl_pkg::dp_stat_type  stat
);
   import sstbl_pkg::*;

   logic signed [KEY_W-1:0] cell_ff [CAPACITY];
   logic signed [KEY_W-1:0] up_src  [CAPACITY];
   logic signed [KEY_W-1:0] dn_src  [CAPACITY];
   logic signed [KEY_W-1:0] key_ff;
   logic [CAPACITY-1:0]     lt_in, lt_ff;
   logic [CAPACITY-1:0]     eq_in, eq_ff;
   logic [CAPACITY-1:0]     lt_below;
   logic [CNT_W-1:0]        count_ff;

   // each occupied cell compares itself against the incoming key
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_in[i] = (CNT_W'(i) < count_ff) && (cell_ff[i] < req_key);
         eq_in[i] = (CNT_W'(i) < count_ff) && (cell_ff[i] == req_key);
      end
   end

   // neighbor sources for the shift paths
   always_comb begin
      up_src[0] = key_ff;
      for (int i = 1; i < CAPACITY; i++) begin
         up_src[i] = cell_ff[i-1];
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         dn_src[i] = cell_ff[i+1];
      end
      dn_src[CAPACITY-1] = cell_ff[CAPACITY-1];
   end

   // cell 0 has nothing smaller below it
   assign lt_below = {lt_ff[CAPACITY-2:0], 1'b1};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_key;
         lt_ff  <= lt_in;
         eq_ff  <= eq_in;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (cmd.shift_up && !lt_ff[i]) begin
            cell_ff[i] <= lt_below[i] ? key_ff : up_src[i];
         end else if (cmd.shift_down && !lt_ff[i]) begin
            cell_ff[i] <= dn_src[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.shift_up) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.shift_down) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   assign stat.hit  = |eq_ff;
   assign stat.full = (count_ff == CNT_W'(CAPACITY));

endmodule

@@ rtl/sorted_set_table.sv @@
// Sorted set table top level: ties the controller to the key cell datapath.
// Depends on sstbl_pkg, sstbl_ctrl and sstbl_dp.
//
// Holds up to CAPACITY distinct signed 32-bit keys in ascending order.
// A request (req_op, req_key) is taken on a rising edge where start is high
// and busy is low. req_op: test membership, insert or delete; the unused
// code leaves the table alone and answers with both flags low.
// Every cell compares itself with the key in the accept cycle; the next
// cycle applies the shift of all cells at once and decides the response.
// Each request gives exactly one response, held for one cycle and marked by
// rsp_valid, registered at the end of the EXEC state after the accept edge.
// busy is high for the one cycle of that EXEC state, so no new request is
// taken until the compare-then-shift pair through the cell row is done.
// rsp_success: key found, inserted or deleted. rsp_full_error: insert of a
// new key into a full table (table unchanged).
// The receiver cannot stall; the response register is free again before
// the next response can form.
// Synchronous reset empties the table (fill count to zero); cell contents
// are not cleared and are never compared above the fill count.
module sorted_set_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_key,
   output logic               rsp_valid,
   output logic               rsp_success,
   output logic               rsp_full_error
);
   import sstbl_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sstbl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_success    (rsp_success),
      .rsp_full_error (rsp_full_error)
   );

   sstbl_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_key (req_key),
      .cmd     (cmd),
      .stat    (stat)
   );

endmodule

@@ sim/sorted_set_table_tb.sv @@
// Self-checking testbench for sorted_set_table: membership, insert and delete
// requests checked against a sorted-queue predictor of the key set.
// Depends on sstbl_pkg and the sorted_set_table RTL.
`timescale 1ns / 100ps

module sorted_set_table_tb;
   import sstbl_pkg::*;

   localparam logic [1:0]         OP_UNUSED      = 2'd3;
   localparam logic signed [31:0] KEY_MIN        = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX        = 32'sh7fff_ffff;
   localparam int                 POOL_SIZE      = 96;
   localparam int                 RANDOM_ITEMS   = 950;
   localparam int                 TIMEOUT_CYCLES = 200000;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] key_val;
      logic               success;
      logic               full_error;
   } outcome_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_op;
   logic signed [31:0] req_key;
   logic               rsp_valid;
   logic               rsp_success;
   logic               rsp_full_error;

   logic signed [31:0] held_keys[$];     // predicted contents, ascending
   outcome_type        outcome_q[$];     // predicted responses in request order
   logic signed [31:0] key_pool[POOL_SIZE];
   int                 mismatches  = 0;
   int                 cycle_count = 0;
   int                 burst_left  = 0;

   sorted_set_table dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_success    (rsp_success),
      .rsp_full_error (rsp_full_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("FAIL sorted_set_table");
         $finish;
      end
   end

   // Updates the predicted set with one request and returns its response.
   function automatic outcome_type apply_request(logic [1:0] op,
                                                 logic signed [31:0] key_val);
      outcome_type o;
      int          pos;
      bit          hit;
      o.op         = op;
      o.key_val    = key_val;
      o.success    = 1'b0;
      o.full_error = 1'b0;
      pos = 0;
      while (pos < held_keys.size() && held_keys[pos] < key_val)
         pos++;
      hit = (pos < held_keys.size()) && (held_keys[pos] == key_val);
      case (op)
         OP_TEST: begin
            o.success = hit;
         end
         OP_INSERT: begin
            if (!hit) begin
               if (held_keys.size() >= CAPACITY) begin
                  o.full_error = 1'b1;
               end else begin
                  held_keys.insert(pos, key_val);
                  o.success = 1'b1;
               end
            end
         end
         OP_DELETE: begin
            if (hit) begin
               held_keys.delete(pos);
               o.success = 1'b1;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic send_request(logic [1:0] op, logic signed [31:0] key_val);
      @(negedge clock);
      start   <= 1'b1;
      req_op  <= op;
      req_key <= key_val;
      do
         @(posedge clock);
      while (busy);
      outcome_q.push_back(apply_request(op, key_val));
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Bursts of back-to-back requests, mostly separated by random gaps.
   task automatic paced_request(logic [1:0] op, logic signed [31:0] key_val);
      if (burst_left == 0) begin
         if ($urandom_range(3) != 0)
            idle_cycles($urandom_range(5, 1));
         burst_left = $urandom_range(24, 1);
      end
      burst_left--;
      send_request(op, key_val);
   endtask

   task automatic test_directed;
      paced_request(OP_TEST, 32'sd0);
      paced_request(OP_DELETE, 32'sd0);
      paced_request(OP_INSERT, 32'sd0);
      paced_request(OP_INSERT, KEY_MIN);
      paced_request(OP_INSERT, KEY_MAX);
      paced_request(OP_INSERT, -32'sd1);
      paced_request(OP_INSERT, 32'sd1);
      paced_request(OP_INSERT, KEY_MIN);   // duplicate at the lowest entry
      paced_request(OP_INSERT, 32'sd0);    // duplicate in the middle
      paced_request(OP_INSERT, KEY_MAX);   // duplicate at the top
      paced_request(OP_TEST, KEY_MIN);
      paced_request(OP_TEST, KEY_MAX);
      paced_request(OP_TEST, -32'sd1);
      paced_request(OP_TEST, 32'sd2);
      paced_request(OP_DELETE, KEY_MIN);
      paced_request(OP_TEST, KEY_MIN);
      paced_request(OP_DELETE, KEY_MAX);
      paced_request(OP_DELETE, 32'sd5);
      paced_request(OP_UNUSED, 32'sd0);
      paced_request(OP_TEST, 32'sd0);
      paced_request(OP_UNUSED, KEY_MAX);
      paced_request(OP_DELETE, 32'sd0);
      paced_request(OP_DELETE, -32'sd1);
      paced_request(OP_DELETE, 32'sd1);
   endtask

   task automatic test_full_store;
      int k;
      while (held_keys.size() < CAPACITY)
         paced_request(OP_INSERT, $urandom);
      paced_request(OP_INSERT, $urandom);
      paced_request(OP_INSERT, KEY_MIN);
      paced_request(OP_INSERT, KEY_MAX);
      paced_request(OP_INSERT, held_keys[0]);             // duplicate while full
      paced_request(OP_INSERT, held_keys[CAPACITY - 1]);
      paced_request(OP_INSERT, held_keys[CAPACITY / 2]);
      paced_request(OP_TEST, held_keys[CAPACITY - 1]);
      paced_request(OP_DELETE, held_keys[CAPACITY - 1]);
      paced_request(OP_INSERT, KEY_MAX);
      paced_request(OP_INSERT, KEY_MIN);
      while (held_keys.size() > 0) begin
         k = $urandom_range(held_keys.size() - 1);
         if ($urandom_range(7) == 0)
            paced_request(OP_DELETE, $urandom);
         else
            paced_request(OP_DELETE, held_keys[k]);
      end
   endtask

   task automatic test_random(int n);
      int                 r;
      bit                 fill_phase;
      logic [1:0]         op;
      logic signed [31:0] key_val;
      foreach (key_pool[i])
         key_pool[i] = $urandom;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = 32'sd0;
      key_pool[3] = -32'sd1;
      fill_phase = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (i % 150 == 149)
            fill_phase = !fill_phase;
         r = $urandom_range(99);
         if (r < 5)
            op = OP_UNUSED;
         else if (r < (fill_phase ? 65 : 25))
            op = OP_INSERT;
         else if (r < (fill_phase ? 82 : 75))
            op = OP_DELETE;
         else
            op = OP_TEST;
         r = $urandom_range(99);
         if (op != OP_INSERT && held_keys.size() > 0 && r < 50)
            key_val = held_keys[$urandom_range(held_keys.size() - 1)];
         else if (r < 88)
            key_val = key_pool[$urandom_range(POOL_SIZE - 1)];
         else
            key_val = $urandom;
         paced_request(op, key_val);
      end
   endtask

   always @(posedge clock) begin : check_reply
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: success %0b full_error %0b",
                        rsp_success, rsp_full_error);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_success !== want.success ||
                rsp_full_error !== want.full_error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch op %0d key %0d: expected success %0b ",
                            "full_error %0b, got %0b %0b"},
                           want.op, want.key_val, want.success, want.full_error,
                           rsp_success, rsp_full_error);
            end
         end
      end
   end

   initial begin
      reset   = 1'b1;
      start   = 1'b0;
      req_op  = OP_TEST;
      req_key = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_full_store();
      test_random(RANDOM_ITEMS);

      @(negedge clock);
      start <= 1'b0;
      while (outcome_q.size() != 0)
         @(posedge clock);
      // catch any stray response after the last one
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("PASS sorted_set_table");
      else
         $display("FAIL sorted_set_table");
      $finish;
   end

endmodule
